>>> sv/message_ring_buffer_defines.svh
// Assertion macros shared by the message ring buffer RTL files.
`ifndef MESSAGE_RING_BUFFER_DEFINES_SVH
`define MESSAGE_RING_BUFFER_DEFINES_SVH

`ifndef ASSERT_OFF

// Concurrent assertion on an explicit clock and active-low reset.
`define MRB_ASSERT_ON(lbl, clock, resetn, prop, msg) \
    lbl: assert property (@(posedge clock) disable iff (!resetn) prop) \
        else $error(msg);

// Concurrent assertion on the module's own clk and rst_n.
`define MRB_ASSERT(lbl, prop, msg) \
    `MRB_ASSERT_ON(lbl, clk, rst_n, prop, msg)

`else

`define MRB_ASSERT_ON(lbl, clock, resetn, prop, msg)

`define MRB_ASSERT(lbl, prop, msg)

`endif

`endif

>>> sv/mrb_pkg.sv
// Types, constants and helper functions of the message ring buffer.
package mrb_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int STORE_SIZE = 256;
    localparam int STORE_AW   = 8;
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 8;
    localparam int FREE_W     = 9;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int TDATA_W    = 16;

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);

    typedef enum logic [OP_W-1:0] {
        OP_WRITE_START = 2'd0,
        OP_WRITE_BYTE  = 2'd1,
        OP_READ_BYTE   = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_WRITE_OK  = 2'd0,
        ST_READ_DATA = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_IGNORED   = 2'd3
    } status_t;

    typedef struct packed {
        status_t             status;
        logic [BYTE_W-1:0]   read_data;
        logic                last;
        logic [LEN_W-1:0]    length;
    } result_t;

    typedef struct packed {
        logic                rd_en;
        logic [SLOT_W-1:0]   rd_addr;
        logic                wr_en;
        logic [SLOT_W-1:0]   wr_addr;
        logic [STORE_AW-1:0] wr_start;
        logic [LEN_W-1:0]    wr_len;
        logic                rel_en;
        logic [SLOT_W-1:0]   rel_addr;
    } slot_cmd_t;

    typedef struct packed {
        logic [STORE_AW-1:0] start;
        logic [LEN_W-1:0]    len;
    } slot_rsp_t;

    typedef struct packed {
        logic                we;
        logic [STORE_AW-1:0] waddr;
        logic [BYTE_W-1:0]   wdata;
        logic                re;
        logic [STORE_AW-1:0] raddr;
    } byte_cmd_t;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        return (s == SLOT_LAST) ? '0 : SLOT_W'(s + 1'b1);
    endfunction

endpackage

>>> sv/mrb_byte_ram.sv
// Byte store of the ring buffer: single-port-write, registered-read RAM.
module mrb_byte_ram
    import mrb_pkg::*;
(
    input  logic              clk,
    input  byte_cmd_t         cmd,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] mem [STORE_SIZE];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            mem[cmd.waddr] <= cmd.wdata;
        end
        if (cmd.re)
        begin
            rdata_reg <= mem[cmd.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/mrb_slot_table.sv
// Slot record table: start and length memory with per-slot occupancy bits.
`include "message_ring_buffer_defines.svh"

module mrb_slot_table
    import mrb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  slot_cmd_t cmd,
    output slot_rsp_t rsp
);

    logic [STORE_AW+LEN_W-1:0] mem [SLOT_COUNT];
    logic [STORE_AW+LEN_W-1:0] rd_data_reg;
    logic [SLOT_COUNT-1:0]     occ_reg;
    logic                      occ_rd_reg;

    // Records are only written; a freed slot just drops its occupancy bit.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= {cmd.wr_start, cmd.wr_len};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[cmd.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg    <= '0;
            occ_rd_reg <= 1'b0;
        end
        else
        begin
            if (cmd.rel_en)
            begin
                occ_reg[cmd.rel_addr] <= 1'b0;
            end
            if (cmd.wr_en)
            begin
                occ_reg[cmd.wr_addr] <= (cmd.wr_len != '0);
            end
            if (cmd.rd_en)
            begin
                occ_rd_reg <= occ_reg[cmd.rd_addr];
            end
        end
    end

    // An empty slot reads as length zero whatever the memory holds.
    assign rsp.start = rd_data_reg[STORE_AW+LEN_W-1:LEN_W];
    assign rsp.len   = occ_rd_reg ? rd_data_reg[LEN_W-1:0] : '0;

    `MRB_ASSERT(a_no_rd_wr_clash, cmd.rd_en && cmd.wr_en |-> cmd.rd_addr != cmd.wr_addr, "slot read and write collide")
    `MRB_ASSERT(a_no_rd_rel_clash, cmd.rd_en && cmd.rel_en |-> cmd.rd_addr != cmd.rel_addr, "slot read and release collide")
    `MRB_ASSERT(a_wr_sets_occ, cmd.wr_en && (cmd.wr_len != '0) |=> occ_reg[$past(cmd.wr_addr)], "written slot not occupied")

endmodule

>>> sv/mrb_ctrl.sv
// Sequencer of the ring buffer: pointers, slot scans and the result register.
`include "message_ring_buffer_defines.svh"

module mrb_ctrl
    import mrb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [OP_W-1:0]   in_op,
    input  logic [LEN_W-1:0]  in_len,
    input  logic [BYTE_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output result_t           out_res,
    output slot_cmd_t         slot_cmd,
    input  slot_rsp_t         slot_rsp,
    output byte_cmd_t         ram_cmd,
    input  logic [BYTE_W-1:0] ram_rdata
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EVICT  = 6'b000010,
        S_COMMIT = 6'b000100,
        S_RSCAN  = 6'b001000,
        S_RDATA  = 6'b010000,
        S_HOLD   = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [FREE_W-1:0]   free_reg, free_next;
    logic [SLOT_W-1:0]   ws_reg, ws_next;
    logic [STORE_AW-1:0] wp_reg, wp_next;
    logic [LEN_W-1:0]    wr_reg, wr_next;
    logic [STORE_AW-1:0] rp_reg, rp_next;
    logic [LEN_W-1:0]    rr_reg, rr_next;
    logic [LEN_W-1:0]    rl_reg, rl_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [SLOT_W-1:0]   scan_reg, scan_next;
    logic [SLOT_W-1:0]   cnt_reg, cnt_next;
    result_t             res_reg, res_next;
    result_t             out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic                out_free;
    logic [FREE_W:0]     free_sum;
    logic [FREE_W-1:0]   free_add;
    logic [FREE_W-1:0]   len_ext;
    logic [SLOT_W-1:0]   scan_succ;
    result_t             res_now;
    logic                res_fire;

    assign out_free  = !out_valid_reg || out_ready;
    assign free_sum  = {1'b0, free_reg} + (FREE_W + 1)'(slot_rsp.len);
    assign free_add  = (free_sum > (FREE_W + 1)'(STORE_SIZE)) ? FREE_W'(STORE_SIZE)
                                                               : free_sum[FREE_W-1:0];
    assign len_ext   = FREE_W'(len_reg);
    assign scan_succ = next_slot(scan_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        free_next      = free_reg;
        ws_next        = ws_reg;
        wp_next        = wp_reg;
        wr_next        = wr_reg;
        rp_next        = rp_reg;
        rr_next        = rr_reg;
        rl_next        = rl_reg;
        len_next       = len_reg;
        scan_next      = scan_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        res_now        = '0;
        res_fire       = 1'b0;
        slot_cmd       = '0;
        ram_cmd        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_op)
                        OP_WRITE_START:
                        begin
                            rr_next          = '0;
                            rl_next          = '0;
                            wp_next          = wp_reg + wr_reg;
                            wr_next          = '0;
                            len_next         = in_len;
                            scan_next        = ws_reg;
                            cnt_next         = '0;
                            slot_cmd.rd_en   = 1'b1;
                            slot_cmd.rd_addr = ws_reg;
                            state_next       = S_EVICT;
                        end
                        OP_WRITE_BYTE:
                        begin
                            res_fire = 1'b1;
                            if (wr_reg != '0)
                            begin
                                ram_cmd.we     = 1'b1;
                                ram_cmd.waddr  = wp_reg;
                                ram_cmd.wdata  = in_data;
                                wp_next        = wp_reg + 1'b1;
                                wr_next        = wr_reg - 1'b1;
                                res_now.status = ST_WRITE_OK;
                            end
                            else
                            begin
                                res_now.status = ST_IGNORED;
                            end
                        end
                        OP_READ_BYTE:
                        begin
                            if (rr_reg != '0)
                            begin
                                ram_cmd.re    = 1'b1;
                                ram_cmd.raddr = rp_reg;
                                state_next    = S_RDATA;
                            end
                            else
                            begin
                                scan_next        = ws_reg;
                                cnt_next         = '0;
                                slot_cmd.rd_en   = 1'b1;
                                slot_cmd.rd_addr = ws_reg;
                                state_next       = S_RSCAN;
                            end
                        end
                        default:
                        begin
                            res_fire       = 1'b1;
                            res_now.status = ST_IGNORED;
                        end
                    endcase
                end
            end
            S_EVICT:
            begin
                // Free the slot just read; the first one (the target) always goes.
                slot_cmd.rel_en   = 1'b1;
                slot_cmd.rel_addr = scan_reg;
                free_next         = free_add;
                if ((cnt_reg == SLOT_LAST) || (free_add >= len_ext))
                begin
                    state_next = S_COMMIT;
                end
                else
                begin
                    scan_next        = scan_succ;
                    cnt_next         = cnt_reg + 1'b1;
                    slot_cmd.rd_en   = 1'b1;
                    slot_cmd.rd_addr = scan_succ;
                end
            end
            S_COMMIT:
            begin
                slot_cmd.wr_en    = 1'b1;
                slot_cmd.wr_addr  = ws_reg;
                slot_cmd.wr_start = wp_reg;
                slot_cmd.wr_len   = len_reg;
                free_next         = (free_reg >= len_ext) ? (free_reg - len_ext) : '0;
                wr_next           = len_reg;
                ws_next           = next_slot(ws_reg);
                res_fire          = 1'b1;
                res_now.status    = ST_WRITE_OK;
                res_now.length    = len_reg;
                state_next        = S_IDLE;
            end
            S_RSCAN:
            begin
                if (slot_rsp.len != '0)
                begin
                    slot_cmd.rel_en   = 1'b1;
                    slot_cmd.rel_addr = scan_reg;
                    free_next         = free_add;
                    rp_next           = slot_rsp.start;
                    rr_next           = slot_rsp.len;
                    rl_next           = slot_rsp.len;
                    ram_cmd.re        = 1'b1;
                    ram_cmd.raddr     = slot_rsp.start;
                    state_next        = S_RDATA;
                end
                else if (cnt_reg == SLOT_LAST)
                begin
                    res_fire       = 1'b1;
                    res_now.status = ST_EMPTY;
                    state_next     = S_IDLE;
                end
                else
                begin
                    scan_next        = scan_succ;
                    cnt_next         = cnt_reg + 1'b1;
                    slot_cmd.rd_en   = 1'b1;
                    slot_cmd.rd_addr = scan_succ;
                end
            end
            S_RDATA:
            begin
                rp_next           = rp_reg + 1'b1;
                rr_next           = rr_reg - 1'b1;
                res_fire          = 1'b1;
                res_now.status    = ST_READ_DATA;
                res_now.read_data = ram_rdata;
                res_now.last      = (rr_reg == LEN_W'(1));
                res_now.length    = rl_reg;
                state_next        = S_IDLE;
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A finished result goes straight out when it can, else it waits in HOLD.
        if (res_fire)
        begin
            if (out_free)
            begin
                out_next       = res_now;
                out_valid_next = 1'b1;
            end
            else
            begin
                res_next   = res_now;
                state_next = S_HOLD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_reg      <= FREE_W'(STORE_SIZE);
            ws_reg        <= '0;
            wp_reg        <= '0;
            wr_reg        <= '0;
            rp_reg        <= '0;
            rr_reg        <= '0;
            rl_reg        <= '0;
            len_reg       <= '0;
            scan_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_reg      <= free_next;
            ws_reg        <= ws_next;
            wp_reg        <= wp_next;
            wr_reg        <= wr_next;
            rp_reg        <= rp_next;
            rr_reg        <= rr_next;
            rl_reg        <= rl_next;
            len_reg       <= len_next;
            scan_reg      <= scan_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        out_reg <= out_next;
    end

    `MRB_ASSERT(a_free_range, free_reg <= FREE_W'(STORE_SIZE), "free byte count above store size")
    `MRB_ASSERT(a_read_within_msg, rr_reg <= rl_reg, "read remaining exceeds message length")
    `MRB_ASSERT(a_evict_enough, state_reg == S_COMMIT |-> free_reg >= len_ext, "eviction left too little space")

endmodule

>>> sv/message_ring_buffer.sv
// Top level of the variable-length message ring buffer.
//
// Messages of 0 to 255 bytes share a 256-byte circular byte store and are
// tracked in a ring of SLOT_COUNT slot records (start, length). A write_start
// transaction frees the current write slot, then evicts the oldest messages
// from that slot onward until the new length fits, and opens the slot.
// write_byte transactions fill the opened message one byte at a time; bytes
// beyond its length are ignored and answered with status 3. A read_byte
// transaction with no read in progress takes the oldest non-empty slot,
// frees it and returns its first byte; later read_byte transactions return
// the following bytes, the last one flagged on m_tlast. A write_start ends
// any unfinished read. Exactly one result transaction follows each input
// transaction, in order. The block works on one item at a time, and
// s_tready is high whenever the sequencer is idle, even while the previous
// result still waits on the output. A write_byte is answered from the idle
// state. A read_byte of a message already being read issues a registered
// read of the byte RAM and answers from the read-data state. A read_byte
// that opens a message first scans the slot records (1 to SLOT_COUNT are
// inspected, all of them when every slot is empty); a write_start visits 1
// to SLOT_COUNT slots during eviction and then commits the new record.
// These scans step through the slot memory one record per cycle. A result
// that meets a stalled output waits in HOLD until m_tready returns.
// Slot occupancy is kept in flip-flops cleared by reset, so the block is
// ready right after reset with no clearing pass.
module message_ring_buffer
    import mrb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [TDATA_W-1:0]  s_tdata,   // [7:0] msg_length, [15:8] data_byte
    input  logic [OP_W-1:0]     s_tuser,   // [1:0] operation
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [TDATA_W-1:0]  m_tdata,   // [7:0] read_data, [15:8] message_length
    output logic [STATUS_W-1:0] m_tuser,   // [1:0] status
    output logic                m_tlast    // last_of_message
);

    slot_cmd_t         slot_cmd;
    slot_rsp_t         slot_rsp;
    byte_cmd_t         ram_cmd;
    logic [BYTE_W-1:0] ram_rdata;
    result_t           out_res;

    // The sequencer owns all pointers and counters and the result register.
    mrb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_len    (s_tdata[LEN_W-1:0]),
        .in_data   (s_tdata[LEN_W+BYTE_W-1:LEN_W]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res),
        .slot_cmd  (slot_cmd),
        .slot_rsp  (slot_rsp),
        .ram_cmd   (ram_cmd),
        .ram_rdata (ram_rdata)
    );

    // Slot records: one read, one write and one release per cycle at most.
    mrb_slot_table u_slot_table (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (slot_cmd),
        .rsp   (slot_rsp)
    );

    // Message bytes; a read may return a byte that was never written.
    mrb_byte_ram u_byte_ram (
        .clk   (clk),
        .cmd   (ram_cmd),
        .rdata (ram_rdata)
    );

    assign m_tdata = {out_res.length, out_res.read_data};
    assign m_tuser = out_res.status;
    assign m_tlast = out_res.last;

endmodule
